[rtl/brightness_run_pixel_sorter_assert.svh]
// Assertion macros used by the pixel sorter RTL.
`ifndef BRIGHTNESS_RUN_PIXEL_SORTER_ASSERT_SVH
`define BRIGHTNESS_RUN_PIXEL_SORTER_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked on clk_i, off while rst_ni is low
`define BRPS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("brps assertion failed");
// Checked on clk_i at every edge, reset included
`define BRPS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("brps assertion failed");
`else
`define BRPS_ASSERT(lbl, prop)
`define BRPS_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[rtl/brps_pkg.sv]
package brps_pkg;

  localparam int MAX_RUN = 64;
  localparam int IDX_W   = $clog2(MAX_RUN);
  localparam int CNT_W   = IDX_W + 1;
  localparam int LUMA_W  = 8;
  localparam int PIX_W   = 32;
  localparam int KEY_W   = LUMA_W + IDX_W;
  localparam int MEM_W   = LUMA_W + PIX_W;

  // Rec.709 weights in Q16
  localparam logic [15:0] COEF_R = 16'd13933;
  localparam logic [15:0] COEF_G = 16'd46871;
  localparam logic [15:0] COEF_B = 16'd4732;

  localparam logic [7:0] THR_RESET = 8'd128;
  localparam logic [5:0] LIM_RESET = 6'd63;

  // register indexes
  localparam logic CFG_THRESH = 1'b0;
  localparam logic CFG_LIMIT  = 1'b1;

endpackage

[rtl/brps_ram.sv]
module brps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/brps_luma.sv]
module brps_luma import brps_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  output logic [LUMA_W-1:0] luma_o
);

  logic [23:0] pr_q, pg_q, pb_q;
  logic [23:0] sum;

  // weighted channels, registered on accept
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pr_q <= 24'(COEF_R * red_i);
      pg_q <= 24'(COEF_G * green_i);
      pb_q <= 24'(COEF_B * blue_i);
    end
  end

  // weights sum to 1.0, so the total stays below 2^24
  assign sum    = pr_q + pg_q + pb_q;
  assign luma_o = sum[23:16];

endmodule

[rtl/brightness_run_pixel_sorter.sv]
// Luminance run pixel sorter. Pixels are buffered as a run in one 64-entry
// RAM; a bright pixel or a full run closes the run, which is emitted sorted
// by ascending luma (stable), and a row end flushes the pending run in
// arrival order. One word at a time: no new pixel is taken until the last one is
// through, a closing run costs one full RAM scan per sorted pixel, set by the
// single read port, and any output stall holds the block.
`include "brightness_run_pixel_sorter_assert.svh"

module brightness_run_pixel_sorter import brps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] red_i,
  input  logic [7:0] green_i,
  input  logic [7:0] blue_i,
  input  logic [7:0] alpha_i,
  input  logic       last_in_row_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_red_o,
  output logic [7:0] out_green_o,
  output logic [7:0] out_blue_o,
  output logic [7:0] out_alpha_o,
  output logic       run_last_o,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [7:0] cfg_data_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_DEC, S_SCAN, S_FETCH, S_EMIT, S_WR, S_URD, S_UEMIT
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [7:0]       thr_q;
  logic [5:0]       lim_q;
  logic             close_q, close_d, last_q, last_d;
  logic [PIX_W-1:0] pix_q, pix_d;
  logic [IDX_W-1:0] addr_q, addr_d, chk_idx_q, chk_idx_d, emit_n_q, emit_n_d;
  logic             iss_q, iss_d, chk_vld_q, chk_vld_d, first_q, first_d;
  logic [KEY_W-1:0] best_q, best_d, prev_q, prev_d, key;
  logic             out_valid_q, out_valid_d, run_last_q, run_last_d;
  logic [PIX_W-1:0] out_pix_q, out_pix_d;

  logic              in_acc, out_free, close, we;
  logic [LUMA_W-1:0] luma;
  logic [CNT_W-1:0]  lim_eff;
  logic [IDX_W-1:0]  cnt_m1, wa, ra;
  logic [MEM_W-1:0]  rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cnt_m1     = IDX_W'(cnt_q - CNT_W'(1));
  assign lim_eff    = (16'(lim_q) > 16'(MAX_RUN - 1)) ? CNT_W'(MAX_RUN - 1) : CNT_W'(lim_q);
  assign close      = ((luma > thr_q) || (cnt_q >= lim_eff)) && (cnt_q != '0);
  assign key        = {rdata[MEM_W-1:PIX_W], chk_idx_q};

  brps_luma u_luma (
    .clk_i   (clk_i),
    .en_i    (in_acc),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .luma_o  (luma)
  );

  // {luma, pixel} per run entry
  brps_ram #(.WIDTH(MEM_W), .DEPTH(MAX_RUN)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wa),
    .wdata_i ({luma, pix_q}),
    .raddr_i (ra),
    .rdata_o (rdata)
  );

  // sequencer: repeated min-key scans give a stable sort
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    close_d     = close_q;
    last_d      = last_q;
    pix_d       = pix_q;
    addr_d      = addr_q;
    iss_d       = iss_q;
    chk_vld_d   = chk_vld_q;
    chk_idx_d   = chk_idx_q;
    emit_n_d    = emit_n_q;
    first_d     = first_q;
    best_d      = best_q;
    prev_d      = prev_q;
    out_valid_d = out_valid_q && out_stall_i;
    run_last_d  = run_last_q;
    out_pix_d   = out_pix_q;
    we          = 1'b0;
    wa          = cnt_q[IDX_W-1:0];
    ra          = addr_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          pix_d   = {alpha_i, blue_i, green_i, red_i};
          last_d  = last_in_row_i;
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        close_d = close;
        if (close) begin
          addr_d    = '0;
          iss_d     = 1'b1;
          chk_vld_d = 1'b0;
          best_d    = '1;
          first_d   = 1'b1;
          emit_n_d  = '0;
          state_d   = S_SCAN;
        end else begin
          state_d = S_WR;
        end
      end
      S_SCAN: begin
        if (iss_q) begin
          chk_vld_d = 1'b1;
          chk_idx_d = addr_q;
          if (addr_q == cnt_m1) iss_d = 1'b0;
          else addr_d = addr_q + IDX_W'(1);
        end else begin
          chk_vld_d = 1'b0;
        end
        if (chk_vld_q) begin
          if ((first_q || key > prev_q) && key < best_q) best_d = key;
          if (chk_idx_q == cnt_m1) state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        ra      = best_q[IDX_W-1:0];
        state_d = S_EMIT;
      end
      S_EMIT: begin
        ra = best_q[IDX_W-1:0];
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pix_d   = rdata[PIX_W-1:0];
          run_last_d  = (emit_n_q == cnt_m1) && !last_q;
          prev_d      = best_q;
          first_d     = 1'b0;
          best_d      = '1;
          addr_d      = '0;
          iss_d       = 1'b1;
          chk_vld_d   = 1'b0;
          emit_n_d    = emit_n_q + IDX_W'(1);
          state_d     = (emit_n_q == cnt_m1) ? S_WR : S_SCAN;
        end
      end
      S_WR: begin
        we    = 1'b1;
        wa    = close_q ? '0 : cnt_q[IDX_W-1:0];
        cnt_d = close_q ? CNT_W'(1) : cnt_q + CNT_W'(1);
        if (last_q) begin
          addr_d  = '0;
          state_d = S_URD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_URD: begin
        state_d = S_UEMIT;
      end
      S_UEMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pix_d   = rdata[PIX_W-1:0];
          run_last_d  = (addr_q == cnt_m1);
          if (addr_q == cnt_m1) begin
            cnt_d   = '0;
            state_d = S_IDLE;
          end else begin
            addr_d  = addr_q + IDX_W'(1);
            state_d = S_URD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      iss_q       <= 1'b0;
      chk_vld_q   <= 1'b0;
      first_q     <= 1'b1;
      close_q     <= 1'b0;
      last_q      <= 1'b0;
      emit_n_q    <= '0;
      addr_q      <= '0;
      best_q      <= '1;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      iss_q       <= iss_d;
      chk_vld_q   <= chk_vld_d;
      first_q     <= first_d;
      close_q     <= close_d;
      last_q      <= last_d;
      emit_n_q    <= emit_n_d;
      addr_q      <= addr_d;
      best_q      <= best_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    pix_q      <= pix_d;
    chk_idx_q  <= chk_idx_d;
    prev_q     <= prev_d;
    out_pix_q  <= out_pix_d;
    run_last_q <= run_last_d;
  end

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
      lim_q <= LIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_THRESH: thr_q <= cfg_data_i;
        CFG_LIMIT:  lim_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_pix_q[7:0];
  assign out_green_o = out_pix_q[15:8];
  assign out_blue_o  = out_pix_q[23:16];
  assign out_alpha_o = out_pix_q[31:24];
  assign run_last_o  = run_last_q;

  `BRPS_ASSERT(a_cnt_range, cnt_q <= CNT_W'(MAX_RUN - 1))
  `BRPS_ASSERT(a_best_found, (state_q == S_FETCH) |-> (best_q != '1))
  `BRPS_ASSERT(a_out_held, (out_valid_q && out_stall_i) |=> out_valid_q)

endmodule

[test/testbench.sv]
module testbench;
  import brps_pkg::*;

  // one emitted pixel
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       run_last;
  } pix_word_t;

  // Tracks buffered runs and queues the pixels the sorter should emit
  class sort_scoreboard;
    pix_word_t run_buf[MAX_RUN];
    logic [7:0] luma_buf[MAX_RUN];
    int unsigned run_len;
    logic [7:0] thresh;
    logic [5:0] limit;
    pix_word_t expected_pixels[$];
    int errors;

    function void clear();
      run_len = 0;
      thresh = THR_RESET;
      limit = LIM_RESET;
      expected_pixels.delete();
      errors = 0;
    endfunction

    function logic [7:0] luma_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      logic [31:0] acc;
      acc = 32'(COEF_R) * r + 32'(COEF_G) * g + 32'(COEF_B) * b;
      return acc[23:16];
    endfunction

    // stable selection: emit by ascending luma, earliest first on ties
    function void flush_sorted();
      bit taken[MAX_RUN];
      int best;
      for (int i = 0; i < MAX_RUN; i++) taken[i] = 0;
      for (int k = 0; k < run_len; k++) begin
        best = -1;
        for (int i = 0; i < run_len; i++)
          if (!taken[i] && (best < 0 || luma_buf[i] < luma_buf[best])) best = i;
        taken[best] = 1;
        expected_pixels.push_back(run_buf[best]);
      end
      run_len = 0;
    endfunction

    function void note_pixel(pix_word_t px);
      logic [7:0] lu;
      int unsigned lim;
      int first;
      first = expected_pixels.size();
      lu = luma_of(px.red, px.green, px.blue);
      lim = (limit > MAX_RUN - 1) ? MAX_RUN - 1 : limit;
      if ((lu > thresh || run_len >= lim) && run_len > 0) flush_sorted();
      if (run_len < MAX_RUN) begin
        run_buf[run_len] = px;
        run_buf[run_len].run_last = 0;
        luma_buf[run_len] = lu;
        run_len++;
      end
      if (px.run_last) begin
        for (int i = 0; i < run_len; i++) expected_pixels.push_back(run_buf[i]);
        run_len = 0;
      end
      if (expected_pixels.size() > first)
        expected_pixels[expected_pixels.size() - 1].run_last = 1;
    endfunction

    function void check_pixel(pix_word_t got);
      pix_word_t exp_px;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected output %h", $time, got);
        errors++;
        return;
      end
      exp_px = expected_pixels.pop_front();
      if (got !== exp_px) begin
        $display("%0t: mismatch expected r%h g%h b%h a%h l%b got r%h g%h b%h a%h l%b",
                 $time, exp_px.red, exp_px.green, exp_px.blue, exp_px.alpha,
                 exp_px.run_last, got.red, got.green, got.blue, got.alpha,
                 got.run_last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic in_valid_i = 0, last_in_row_i = 0, out_stall_i = 0;
  logic [7:0] red_i = 0, green_i = 0, blue_i = 0, alpha_i = 0;
  logic in_stall_o, out_valid_o, run_last_o;
  logic [7:0] out_red_o, out_green_o, out_blue_o, out_alpha_o;
  logic cfg_we_i = 0, cfg_idx_i = CFG_THRESH;
  logic [7:0] cfg_data_i = 0;

  sort_scoreboard board = new();
  int send_idle_pct = 0, stall_pct = 0;
  longint cycles = 0;

  brightness_run_pixel_sorter dut (.*);

  always #4 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stall, check on accept
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_pixel({out_red_o, out_green_o, out_blue_o, out_alpha_o, run_last_o});
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  task automatic write_reg(logic idx, logic [7:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == CFG_THRESH) board.thresh = val;
    else board.limit = val[5:0];
  endtask

  task automatic send_pixel(logic [7:0] r, g, b, a, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    red_i <= r; green_i <= g; blue_i <= b; alpha_i <= a; last_in_row_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    board.note_pixel({r, g, b, a, last});
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (board.expected_pixels.size() > 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  // random row: mostly dim pixels so runs grow, some bright closers
  task automatic send_row(int len);
    logic [7:0] lvl;
    for (int i = 0; i < len; i++) begin
      lvl = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(120));
      send_pixel(lvl ^ 8'($urandom_range(15)), lvl, lvl ^ 8'($urandom_range(15)),
                 8'($urandom), i == len - 1);
    end
  endtask

  initial begin
    board.clear();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, ties, row ends with and without a close
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00, 0);
    send_pixel(8'hff, 8'hff, 8'hff, 8'hff, 0);
    send_pixel(8'h10, 8'h10, 8'h10, 8'h01, 0);
    send_pixel(8'h10, 8'h10, 8'h10, 8'h02, 0);
    send_pixel(8'h05, 8'h05, 8'h05, 8'h03, 0);
    send_pixel(8'hff, 8'h00, 8'h00, 8'haa, 0);
    send_pixel(8'h00, 8'h00, 8'hff, 8'h55, 0);
    send_pixel(8'h00, 8'hff, 8'h00, 8'h0f, 1);
    send_pixel(8'h20, 8'h20, 8'h20, 8'hf0, 1);
    drain();
    write_reg(CFG_THRESH, 8'd0);
    write_reg(CFG_LIMIT, 8'd0);
    send_pixel(8'h00, 8'h00, 8'h00, 8'h11, 0);
    send_pixel(8'h01, 8'h01, 8'h01, 8'h22, 0);
    send_pixel(8'h80, 8'h80, 8'h80, 8'h33, 1);
    drain();
    write_reg(CFG_THRESH, 8'd255);
    write_reg(CFG_LIMIT, 8'd4);
    for (int i = 0; i < 6; i++)
      send_pixel(8'(8'hff - i), 8'hff, 8'(i), 8'(i), 0);
    drain();
    // lower the limit mid-run
    write_reg(CFG_LIMIT, 8'd2);
    send_pixel(8'h40, 8'h40, 8'h40, 8'h77, 1);
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 50; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 50; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      write_reg(CFG_THRESH, (ph == 0) ? 8'd255 : (ph == 1) ? 8'd0 :
                            8'($urandom_range(60, 200)));
      write_reg(CFG_LIMIT, (ph == 2) ? 8'd63 : (ph == 3) ? 8'd1 :
                           8'($urandom_range(1, 20)));
      for (int n = 0; n < 38; ) begin
        int len;
        len = (ph == 2) ? $urandom_range(10, 70) : $urandom_range(1, 12);
        send_row(len);
        n += len;
      end
      drain();
    end

    if (board.errors == 0 && board.expected_pixels.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl
rtl/brps_pkg.sv
rtl/brps_ram.sv
rtl/brps_luma.sv
rtl/brightness_run_pixel_sorter.sv
test/testbench.sv
